// ----- rtl/gub_pkg.sv -----
// gub_pkg: shared types and constants for the grid uv bilinear row generator
// no dependencies; used by gub_lane and grid_uv_bilinear_row
package gub_pkg;

  localparam int CRD_W = 32;           // corner and post coordinate width, Q16.16
  localparam int ROW_W = 5;            // row and column index width
  localparam int PWR_W = 3;            // grid power field width
  localparam int DW    = 40;           // internal exact datapath width
  localparam int MAX_POWER_DEF = 4;

  // operation of the shared arithmetic unit, one per sequencer step
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_EA,
    OP_EB,
    OP_START,
    OP_END,
    OP_STEP,
    OP_ADV
  } gub_op_t;

  typedef struct packed {
    gub_op_t            op;
    logic [PWR_W-1:0]   pwr;
    logic [ROW_W-1:0]   row;
  } gub_ctrl_t;

endpackage

// ----- rtl/gub_lane.sv -----
// gub_lane: one coordinate lane (u or v) with a shared add / multiply / shift unit
// depends on gub_pkg for widths, operation codes and the control struct
module gub_lane (
  input  logic                              clk,
  input  gub_pkg::gub_ctrl_t                ctrl,
  input  logic signed [gub_pkg::CRD_W-1:0]  c0,
  input  logic signed [gub_pkg::CRD_W-1:0]  c1,
  input  logic signed [gub_pkg::CRD_W-1:0]  c2,
  input  logic signed [gub_pkg::CRD_W-1:0]  c3,
  output logic signed [gub_pkg::CRD_W-1:0]  post
);

  localparam int DW = gub_pkg::DW;
  localparam int CW = gub_pkg::CRD_W;
  localparam int RW = gub_pkg::ROW_W;

  logic signed [CW-1:0] c0_r, c1_r, c2_r, c3_r;
  logic signed [DW-1:0] ea_r, eb_r, acc_r, end_r, step_r;

  logic signed [DW-1:0]   x, y, sum, res;
  logic        [RW-1:0]   k;
  logic                   mac, shf;
  logic signed [DW+RW:0]  prod_full;
  logic signed [DW-1:0]   prod;

  always_comb begin
    x   = '0;
    y   = '0;
    k   = '0;
    mac = 1'b0;
    shf = 1'b0;
    unique case (ctrl.op)
      gub_pkg::OP_EA: begin
        x = DW'(c1_r); y = DW'(c0_r); shf = 1'b1;
      end
      gub_pkg::OP_EB: begin
        x = DW'(c2_r); y = DW'(c3_r); shf = 1'b1;
      end
      gub_pkg::OP_START: begin
        x = DW'(c0_r); y = ea_r; k = ctrl.row; mac = 1'b1;
      end
      gub_pkg::OP_END: begin
        x = DW'(c3_r); y = eb_r; k = ctrl.row; mac = 1'b1;
      end
      gub_pkg::OP_STEP: begin
        x = end_r; y = acc_r; shf = 1'b1;
      end
      gub_pkg::OP_ADV: begin
        x = acc_r; y = step_r; k = RW'(1); mac = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
  end

  // x + y*k, or floor((x - y) / 2^p) as an arithmetic shift
  assign prod_full = y * $signed({1'b0, k});
  assign prod      = prod_full[DW-1:0];
  assign sum       = mac ? (x + prod) : (x - y);
  assign res       = shf ? (sum >>> ctrl.pwr) : sum;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      gub_pkg::OP_LOAD: begin
        c0_r <= c0;
        c1_r <= c1;
        c2_r <= c2;
        c3_r <= c3;
      end
      gub_pkg::OP_EA:    ea_r   <= res;
      gub_pkg::OP_EB:    eb_r   <= res;
      gub_pkg::OP_START: acc_r  <= res;
      gub_pkg::OP_END:   end_r  <= res;
      gub_pkg::OP_STEP:  step_r <= res;
      gub_pkg::OP_ADV:   acc_r  <= res;
      default: begin
      end
    endcase
  end

  // saturate: in range when all bits above bit 30 agree
  always_comb begin
    if (&acc_r[DW-1:CW-1] || ~|acc_r[DW-1:CW-1]) begin
      post = acc_r[CW-1:0];
    end else if (acc_r[DW-1]) begin
      post = {1'b1, {(CW-1){1'b0}}};
    end else begin
      post = {1'b0, {(CW-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/grid_uv_bilinear_row.sv -----
// grid_uv_bilinear_row: top level, sequencer and output for one grid row of uv posts
// depends on gub_pkg and gub_lane (one lane each for u and v)
//
// One word in carries four corner uvs, a grid power and a row index, and gives the
// 2^p+1 posts of that row, one word out each, column 0 first, the last one flagged.
// The power is clamped to MAX_POWER; a row index above 2^p is taken and gives no
// output. For a row the block takes the word, then runs five setup steps of the shared
// add, multiply and shift unit in each lane (both edge slopes, both row endpoints,
// the column step), then gives one post per cycle while out_ready is high, by
// accumulating the step. in_ready is high only while the block is idle.
module grid_uv_bilinear_row #(
  parameter int MAX_POWER = gub_pkg::MAX_POWER_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gub_pkg::ROW_W-1:0]          in_row_index,
  input  logic [gub_pkg::PWR_W-1:0]          in_grid_power,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner0_u,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner0_v,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner1_u,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner1_v,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner2_u,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner2_v,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner3_u,
  input  logic signed [gub_pkg::CRD_W-1:0]   in_corner3_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gub_pkg::ROW_W-1:0]          out_row,
  output logic [gub_pkg::ROW_W-1:0]          out_col,
  output logic signed [gub_pkg::CRD_W-1:0]   out_post_u,
  output logic signed [gub_pkg::CRD_W-1:0]   out_post_v,
  output logic                               out_row_last
);

  localparam int RW    = gub_pkg::ROW_W;
  localparam int PW    = gub_pkg::PWR_W;
  localparam int CNT_W = (MAX_POWER + 1 > RW) ? MAX_POWER + 1 : RW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EA,
    S_EB,
    S_START,
    S_END,
    S_STEP,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [PW-1:0]        pwr_r, pwr_nxt;
  logic [CNT_W-1:0]     col_r, col_nxt;

  logic                 in_acc, out_acc;
  logic [PW-1:0]        pwr_in;
  logic [CNT_W-1:0]     side_in, last_col;
  logic                 row_ok;
  gub_pkg::gub_ctrl_t   ctrl;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pwr_in   = (in_grid_power > PW'(MAX_POWER)) ? PW'(MAX_POWER) : in_grid_power;
  assign side_in  = CNT_W'(1) << pwr_in;
  assign row_ok   = CNT_W'(in_row_index) <= side_in;
  assign last_col = CNT_W'(1) << pwr_r;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    pwr_nxt   = pwr_r;
    col_nxt   = col_r;
    ctrl.op   = gub_pkg::OP_HOLD;
    ctrl.pwr  = pwr_r;
    ctrl.row  = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctrl.op = gub_pkg::OP_LOAD;
          row_nxt = in_row_index;
          pwr_nxt = pwr_in;
          col_nxt = '0;
          if (row_ok) begin
            state_nxt = S_EA;
          end
        end
      end
      S_EA: begin
        ctrl.op   = gub_pkg::OP_EA;
        state_nxt = S_EB;
      end
      S_EB: begin
        ctrl.op   = gub_pkg::OP_EB;
        state_nxt = S_START;
      end
      S_START: begin
        ctrl.op   = gub_pkg::OP_START;
        state_nxt = S_END;
      end
      S_END: begin
        ctrl.op   = gub_pkg::OP_END;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        ctrl.op   = gub_pkg::OP_STEP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (col_r == last_col) begin
            state_nxt = S_IDLE;
          end else begin
            ctrl.op = gub_pkg::OP_ADV;
            col_nxt = col_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
    row_r <= row_nxt;
    pwr_r <= pwr_nxt;
  end

  gub_lane u_lane_u (
    .clk  (clk),
    .ctrl (ctrl),
    .c0   (in_corner0_u),
    .c1   (in_corner1_u),
    .c2   (in_corner2_u),
    .c3   (in_corner3_u),
    .post (out_post_u)
  );

  gub_lane u_lane_v (
    .clk  (clk),
    .ctrl (ctrl),
    .c0   (in_corner0_v),
    .c1   (in_corner1_v),
    .c2   (in_corner2_v),
    .c3   (in_corner3_v),
    .post (out_post_v)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_EMIT);
  assign out_row      = row_r;
  assign out_col      = col_r[RW-1:0];
  assign out_row_last = (col_r == last_col);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a row is being sent");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> col_r <= last_col)
    else $error("column beyond end of row");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_row_last |=> in_ready)
    else $error("block not idle after last post");

  a_col_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |=> out_valid && col_r == '0)
    else $error("row did not start at column zero");
`endif

endmodule
